// File: hw/rtl/pct_pkg.sv
package pct_pkg;

    // Shape codes carried in the op field of a query word.
    localparam logic [1:0] OP_SPHERE = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_PLANE  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_X     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_Y     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_Z     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_OFFSET = 4'd3;

    // Reset values of the plane registers.
    localparam logic signed [15:0] NORMAL_X_RESET = 16'sd0;
    localparam logic signed [15:0] NORMAL_Y_RESET = 16'sd0;
    localparam logic signed [15:0] NORMAL_Z_RESET = 16'sd16384;
    localparam logic signed [31:0] OFFSET_RESET   = 32'sd0;

    // Shift that brings a Q1.14 by Q16.16 product back to Q16.16.
    localparam int unsigned Q_SHIFT = 14;

    // Plane registers as seen by the datapath.
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] plane_offset;
    } pct_cfg_t;

    // Negate a normal component, clamping the most negative code.
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [16:0] n;
        begin
            n = -17'(v);
            if (n > 17'sd32767)
                neg_sat16 = 16'sh7FFF;
            else
                neg_sat16 = n[15:0];
        end
    endfunction

    // Clamp a contact coordinate into the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        begin
            if (v > 45'sh0_7FFF_FFFF)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < -45'sh0_8000_0000)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[31:0];
        end
    endfunction

    // Clamp a non-negative depth into 31 bits.
    function automatic logic [30:0] sat_depth(input logic signed [39:0] v);
        begin
            if (v > 40'sh00_7FFF_FFFF)
                sat_depth = 31'h7FFF_FFFF;
            else
                sat_depth = v[30:0];
        end
    endfunction

endpackage

// File: hw/rtl/pct_if.sv
// Query channel: one shape to test against the plane.
interface pct_query_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
    logic [30:0]        radius;

    modport source (
        output valid, op, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, radius,
        input  ready
    );
    modport sink (
        input  valid, op, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, radius,
        output ready
    );
endinterface

// Result channel: the outcome of one query.
interface pct_result_if;
    logic               valid;
    logic               ready;
    logic               collided;
    logic [30:0]        depth;
    logic signed [15:0] contact_normal_x;
    logic signed [15:0] contact_normal_y;
    logic signed [15:0] contact_normal_z;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;

    modport source (
        output valid, collided, depth, contact_normal_x, contact_normal_y,
               contact_normal_z, contact_x, contact_y, contact_z,
        input  ready
    );
    modport sink (
        input  valid, collided, depth, contact_normal_x, contact_normal_y,
               contact_normal_z, contact_x, contact_y, contact_z,
        output ready
    );
endinterface

// Configuration write channel.
interface pct_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pct_pkg::CFG_INDEX_W-1:0]   index;
    logic [31:0]                       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: hw/rtl/pct_regs.sv
module pct_regs (
    input  logic              clk,
    input  logic              rst_n,
    pct_cfg_if.sink           cfg,
    output pct_pkg::pct_cfg_t plane
);

    pct_pkg::pct_cfg_t plane_reg;

    // Writes are always taken; an index beyond the list is dropped.
    assign cfg.ready = 1'b1;
    assign plane     = plane_reg;

    // Plane register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.normal_x     <= pct_pkg::NORMAL_X_RESET;
            plane_reg.normal_y     <= pct_pkg::NORMAL_Y_RESET;
            plane_reg.normal_z     <= pct_pkg::NORMAL_Z_RESET;
            plane_reg.plane_offset <= pct_pkg::OFFSET_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pct_pkg::CFG_NORMAL_X:     plane_reg.normal_x     <= cfg.data[15:0];
                pct_pkg::CFG_NORMAL_Y:     plane_reg.normal_y     <= cfg.data[15:0];
                pct_pkg::CFG_NORMAL_Z:     plane_reg.normal_z     <= cfg.data[15:0];
                pct_pkg::CFG_PLANE_OFFSET: plane_reg.plane_offset <= cfg.data;
                default:                   plane_reg              <= plane_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/plane_collision_test.sv
// Plane collision test.
// The plane (unit normal in Q1.14, offset in Q16.16) is held in four
// registers written through the cfg channel; write them only while no query
// is in flight. Each query word on the query channel carries a sphere
// (centre, radius) or an axis-aligned box (minimum and maximum corner); a
// plane shape or an unused op code always gives a miss. Each query word
// yields exactly one result word on the result channel, in order: the hit
// flag, the penetration depth, the normal turned toward the shape and the
// contact point, all zero on a miss.
// The datapath is six register stages long, and a new query word can be taken in
// every cycle while the receiver takes the result words, so the sustained rate is
// one word per cycle. The depth is set by the two rounds of multipliers (plane
// distance, contact offset).
// When the receiver holds ready low, the words stop in their stages and
// empty stages still fill, so the query side keeps being served until the
// whole pipeline is full. Reset empties the pipeline and loads the plane
// registers with a z-up plane through the origin.
module plane_collision_test (
    input  logic      clk,
    input  logic      rst_n,
    pct_cfg_if.sink   cfg,
    pct_query_if.sink query,
    pct_result_if.source result
);

    pct_pkg::pct_cfg_t plane;

    logic signed [15:0] n [3];
    logic signed [31:0] off;

    // Stage enables, valid bits.
    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1: centre and half extents.
    logic               sph1_reg, box1_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] c1_reg [3];
    logic signed [31:0] h1_reg [3];
    logic [30:0]        r1_reg;
    logic signed [31:0] qa [3];
    logic signed [31:0] qb [3];
    logic signed [31:0] c1_next [3];
    logic signed [31:0] h1_next [3];
    logic signed [32:0] sum1 [3];
    logic signed [32:0] dif1 [3];

    // Stage 2: distance and projected-radius products.
    logic               sph2_reg, box2_reg;
    logic signed [31:0] a2_reg [3];
    logic signed [31:0] c2_reg [3];
    logic signed [31:0] h2_reg [3];
    logic [30:0]        r2_reg;
    logic signed [47:0] dp2_reg [3];
    logic signed [49:0] pp2_reg [3];
    logic signed [47:0] dp2_next [3];
    logic signed [49:0] pp2_next [3];
    logic [16:0]        nabs [3];

    // Stage 3: signed distance and radius.
    logic               sph3_reg, box3_reg;
    logic signed [31:0] a3_reg [3];
    logic signed [31:0] c3_reg [3];
    logic signed [31:0] h3_reg [3];
    logic [30:0]        r3_reg;
    logic signed [37:0] s3_reg, rad3_reg;
    logic signed [37:0] s3_next, rad3_next;
    logic signed [49:0] dot3;
    logic signed [51:0] proj3;
    logic signed [35:0] dot3_q;

    // Stage 4: hit test, flipped normal, base point, contact scale.
    logic               sph4_reg, hit4_reg;
    logic [30:0]        depth4_reg;
    logic signed [15:0] m4_reg [3];
    logic signed [33:0] base4_reg [3];
    logic signed [40:0] k4_reg;
    logic signed [37:0] sabs4;
    logic signed [39:0] g4, depth4;
    logic signed [38:0] half4;
    logic               hit4_next;
    logic signed [15:0] m4_next [3];
    logic signed [33:0] base4_next [3];
    logic signed [40:0] k4_next;
    logic signed [32:0] habs4 [3];
    logic signed [33:0] corner4 [3];

    // Stage 5: contact offset products.
    logic               sph5_reg, hit5_reg;
    logic [30:0]        depth5_reg;
    logic signed [15:0] m5_reg [3];
    logic signed [33:0] base5_reg [3];
    logic signed [56:0] prod5_reg [3];

    // Stage 6: output word.
    logic               hit6_reg;
    logic [30:0]        depth6_reg;
    logic signed [15:0] m6_reg [3];
    logic signed [31:0] p6_reg [3];
    logic signed [31:0] p6_next [3];
    logic signed [42:0] t6 [3];
    logic signed [44:0] psum6 [3];

    pct_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .plane (plane)
    );

    assign n[0] = plane.normal_x;
    assign n[1] = plane.normal_y;
    assign n[2] = plane.normal_z;
    assign off  = plane.plane_offset;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en6 = !v6_reg || result.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign query.ready = en1;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= query.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                v6_reg <= v5_reg;
        end
    end

    // Stage 1: box centre and half extents; a sphere keeps its centre.
    assign qa[0] = query.point_a_x;
    assign qa[1] = query.point_a_y;
    assign qa[2] = query.point_a_z;
    assign qb[0] = query.point_b_x;
    assign qb[1] = query.point_b_y;
    assign qb[2] = query.point_b_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum1[i]    = 33'(qa[i]) + 33'(qb[i]);
            dif1[i]    = 33'(qb[i]) - 33'(qa[i]);
            h1_next[i] = dif1[i][32:1];
            if (query.op == pct_pkg::OP_SPHERE)
                c1_next[i] = qa[i];
            else
                c1_next[i] = sum1[i][32:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sph1_reg <= (query.op == pct_pkg::OP_SPHERE);
            box1_reg <= (query.op == pct_pkg::OP_BOX);
            r1_reg   <= query.radius;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= qa[i];
                c1_reg[i] <= c1_next[i];
                h1_reg[i] <= h1_next[i];
            end
        end
    end

    // Stage 2: normal times centre and magnitude of normal times half extent.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nabs[i]     = n[i][15] ? -17'(n[i]) : 17'(n[i]);
            dp2_next[i] = n[i] * c1_reg[i];
            pp2_next[i] = $signed({1'b0, nabs[i]}) * h1_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sph2_reg <= sph1_reg;
            box2_reg <= box1_reg;
            r2_reg   <= r1_reg;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i]  <= a1_reg[i];
                c2_reg[i]  <= c1_reg[i];
                h2_reg[i]  <= h1_reg[i];
                dp2_reg[i] <= dp2_next[i];
                pp2_reg[i] <= pp2_next[i];
            end
        end
    end

    // Stage 3: signed distance to the plane and the shape's reach.
    always_comb
    begin
        dot3    = 50'(dp2_reg[0]) + 50'(dp2_reg[1]) + 50'(dp2_reg[2]);
        proj3   = 52'(pp2_reg[0]) + 52'(pp2_reg[1]) + 52'(pp2_reg[2]);
        dot3_q  = 36'(dot3 >>> pct_pkg::Q_SHIFT);
        s3_next = 38'(dot3_q) - 38'(off);
        if (sph2_reg)
            rad3_next = $signed({7'b0, r2_reg});
        else
            rad3_next = 38'(proj3 >>> pct_pkg::Q_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sph3_reg <= sph2_reg;
            box3_reg <= box2_reg;
            r3_reg   <= r2_reg;
            s3_reg   <= s3_next;
            rad3_reg <= rad3_next;
            for (int i = 0; i < 3; i++)
            begin
                a3_reg[i] <= a2_reg[i];
                c3_reg[i] <= c2_reg[i];
                h3_reg[i] <= h2_reg[i];
            end
        end
    end

    // Stage 4: gap, depth, normal on the shape's side and the base point.
    always_comb
    begin
        sabs4     = s3_reg[37] ? -s3_reg : s3_reg;
        g4        = 40'(sabs4) - 40'(rad3_reg);
        depth4    = -g4;
        half4     = 39'(depth4 >>> 1);
        hit4_next = g4[39] && (sph3_reg || box3_reg);
        if (sph3_reg)
            k4_next = $signed({10'b0, r3_reg}) - 41'(half4);
        else
            k4_next = 41'(half4);
        for (int i = 0; i < 3; i++)
        begin
            m4_next[i] = s3_reg[37] ? pct_pkg::neg_sat16(n[i]) : n[i];
            habs4[i]   = h3_reg[i][31] ? -33'(h3_reg[i]) : 33'(h3_reg[i]);
            if (!m4_next[i][15])
                corner4[i] = 34'(c3_reg[i]) - 34'(habs4[i]);
            else
                corner4[i] = 34'(c3_reg[i]) + 34'(habs4[i]);
            base4_next[i] = sph3_reg ? 34'(a3_reg[i]) : corner4[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sph4_reg   <= sph3_reg;
            hit4_reg   <= hit4_next;
            depth4_reg <= pct_pkg::sat_depth(depth4);
            k4_reg     <= k4_next;
            for (int i = 0; i < 3; i++)
            begin
                m4_reg[i]    <= m4_next[i];
                base4_reg[i] <= base4_next[i];
            end
        end
    end

    // Stage 5: normal times contact scale.
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            sph5_reg   <= sph4_reg;
            hit5_reg   <= hit4_reg;
            depth5_reg <= depth4_reg;
            for (int i = 0; i < 3; i++)
            begin
                m5_reg[i]    <= m4_reg[i];
                base5_reg[i] <= base4_reg[i];
                prod5_reg[i] <= m4_reg[i] * k4_reg;
            end
        end
    end

    // Stage 6: contact point; a sphere steps back from its centre, a box
    // steps out from its deepest corner.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t6[i] = 43'(prod5_reg[i] >>> pct_pkg::Q_SHIFT);
            if (sph5_reg)
                psum6[i] = 45'(base5_reg[i]) - 45'(t6[i]);
            else
                psum6[i] = 45'(base5_reg[i]) + 45'(t6[i]);
            p6_next[i] = pct_pkg::sat32(psum6[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            hit6_reg   <= hit5_reg;
            depth6_reg <= hit5_reg ? depth5_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                m6_reg[i] <= hit5_reg ? m5_reg[i] : '0;
                p6_reg[i] <= hit5_reg ? p6_next[i] : '0;
            end
        end
    end

    assign result.valid            = v6_reg;
    assign result.collided         = hit6_reg;
    assign result.depth            = depth6_reg;
    assign result.contact_normal_x = m6_reg[0];
    assign result.contact_normal_y = m6_reg[1];
    assign result.contact_normal_z = m6_reg[2];
    assign result.contact_x        = p6_reg[0];
    assign result.contact_y        = p6_reg[1];
    assign result.contact_z        = p6_reg[2];

endmodule

// File: hw/rtl/pct_checker.sv
module pct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               collided,
    input logic [30:0]        depth,
    input logic signed [15:0] nx,
    input logic signed [15:0] ny,
    input logic signed [15:0] nz,
    input logic signed [31:0] px,
    input logic signed [31:0] py,
    input logic signed [31:0] pz
);

    // A stalled result word stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its hit flag, depth and contact point.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(depth) && $stable(collided)
            && $stable(px) && $stable(py) && $stable(pz))
        else $error("result word changed while stalled");

    // A miss reports nothing but zeros.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !collided |-> depth == 31'd0 && nx == 16'sd0 && ny == 16'sd0
            && nz == 16'sd0 && px == 32'sd0 && py == 32'sd0 && pz == 32'sd0)
        else $error("miss with non-zero contact data");

    // A hit always penetrates by a non-zero amount.
    a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && collided |-> depth != 31'd0)
        else $error("hit with zero depth");

endmodule

bind plane_collision_test pct_checker u_pct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .collided  (result.collided),
    .depth     (result.depth),
    .nx        (result.contact_normal_x),
    .ny        (result.contact_normal_y),
    .nz        (result.contact_normal_z),
    .px        (result.contact_x),
    .py        (result.contact_y),
    .pz        (result.contact_z)
);
